>>> design/midpoint_pool_downscaler_unit_defines.svh
// assertion macros for the midpoint pool downscaler
`ifndef MIDPOINT_POOL_DOWNSCALER_UNIT_DEFINES_SVH
`define MIDPOINT_POOL_DOWNSCALER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mpd assertion failed (same cycle)");

// next-cycle implication, disabled in reset
`define MPD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mpd assertion failed (next cycle)");

`endif

>>> design/mpd_pkg.sv
// types, constants and channel functions of the midpoint pool downscaler
`timescale 1ns / 1ps
`default_nettype none
package mpd_pkg;

    localparam int PIX_W      = 16;
    localparam int COORD_W    = 10;
    localparam int EXT_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [EXT_W-1:0] EXT_INIT = 48'h00FF_00FF_00FF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT = 3'd0,
        CFG_BLOCK_WIDTH  = 3'd1,
        CFG_BLOCK_HEIGHT = 3'd2,
        CFG_IMAGE_WIDTH  = 3'd3,
        CFG_IMAGE_HEIGHT = 3'd4,
        CFG_BIAS         = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic in_tile;
        logic first_col;
        logic first_row;
        logic last_col;
        logic last_row;
        logic done;
    } t_meta;

    // min in bits 7:0, max in bits 15:8
    function automatic logic [15:0] merge8(input logic [15:0] e, input logic [7:0] v);
        logic [7:0] mn;
        logic [7:0] mx;
        mn = (v < e[7:0]) ? v : e[7:0];
        mx = (v > e[15:8]) ? v : e[15:8];
        return {mx, mn};
    endfunction

    function automatic logic [7:0] blend8(input logic [15:0] e, input logic [8:0] w);
        logic [16:0] a;
        logic [16:0] b;
        logic [16:0] s;
        a = 17'(e[7:0]) * 17'(9'd256 - w);
        b = 17'(e[15:8]) * 17'(w);
        s = a + b;
        return s[15:8];
    endfunction

endpackage
`default_nettype wire

>>> design/mpd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mpd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> design/midpoint_pool_downscaler_unit.sv
// top level of the midpoint pool downscaler: tile counters, min/max merge, blend
`timescale 1ns / 1ps
`default_nettype none
`include "midpoint_pool_downscaler_unit_defines.svh"
// Takes one pixel per clock in raster order when not stalled (grayscale in bits 7:0
// or RGB565) and emits one pooled pixel per whole tile, (min*(256-bias) + max*bias)
// >> 8 per channel, with its tile column, tile row and a flag on the last tile of
// the frame. A pixel is accepted every cycle unless a finished tile waits on a
// stalled blend stage. A result passes the merge stage, the blend stage and the output
// register after the last pixel of its tile is accepted, and holds there while the
// receiver stalls. Partial extremes of a tile row live in a MAX_WIDTH-entry ram with
// one write and one read port. A write to config indices 0 to 5 restarts the frame.
module midpoint_pool_downscaler_unit
    import mpd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [PIX_W-1:0]      i_in_pixel,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [PIX_W-1:0]      o_out_pixel,
    output logic      [COORD_W-1:0]    o_out_col,
    output logic      [COORD_W-1:0]    o_out_row,
    output logic                       o_frame_done
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int MW  = (CW > RW) ? CW : RW;
    localparam int KW  = ((MW > CFG_DATA_W) ? MW : CFG_DATA_W) + 2;

    // configuration
    logic                  r_fmt;
    logic [7:0]            r_bw;
    logic [7:0]            r_bh;
    logic [CFG_DATA_W-1:0] r_iw;
    logic [CFG_DATA_W-1:0] r_ih;
    logic [8:0]            r_bias;
    logic                  restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= 1'b0;
            r_bw   <= 8'd2;
            r_bh   <= 8'd2;
            r_iw   <= CFG_DATA_W'(320);
            r_ih   <= CFG_DATA_W'(240);
            r_bias <= 9'd128;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PIXEL_FORMAT: r_fmt  <= i_cfg_data[0];
                CFG_BLOCK_WIDTH:  r_bw   <= i_cfg_data[7:0];
                CFG_BLOCK_HEIGHT: r_bh   <= i_cfg_data[7:0];
                CFG_IMAGE_WIDTH:  r_iw   <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_ih   <= i_cfg_data;
                CFG_BIAS:         r_bias <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_cfg_idx'(i_cfg_index))
            CFG_PIXEL_FORMAT, CFG_BLOCK_WIDTH, CFG_BLOCK_HEIGHT,
            CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_BIAS: restart = i_cfg_we;
            default: restart = 1'b0;
        endcase
    end

    logic [7:0]    bw_eff;
    logic [7:0]    bh_eff;
    logic [KW-1:0] w_eff;
    logic [KW-1:0] h_eff;
    logic [8:0]    wb;

    always_comb begin
        bw_eff = (r_bw == 8'd0) ? 8'd1 : r_bw;
        bh_eff = (r_bh == 8'd0) ? 8'd1 : r_bh;
        if (r_iw == '0) begin
            w_eff = KW'(1);
        end else if (KW'(r_iw) > KW'(MAX_WIDTH)) begin
            w_eff = KW'(MAX_WIDTH);
        end else begin
            w_eff = KW'(r_iw);
        end
        if (r_ih == '0) begin
            h_eff = KW'(1);
        end else if (KW'(r_ih) > KW'(MAX_HEIGHT)) begin
            h_eff = KW'(MAX_HEIGHT);
        end else begin
            h_eff = KW'(r_ih);
        end
        wb = (r_bias > 9'd256) ? 9'd256 : r_bias;
    end

    // position counters, advanced on every input beat
    logic [CW-1:0] r_col_pos;
    logic [CW-1:0] r_col_base;
    logic [CW-1:0] r_tc;
    logic [7:0]    r_col_phase;
    logic [RW-1:0] r_row_pos;
    logic [RW-1:0] r_row_base;
    logic [RW-1:0] r_tr;
    logic [7:0]    r_row_phase;

    logic          in_acc;
    logic [KW-1:0] col_end;
    logic [KW-1:0] row_end_pos;
    logic          in_x;
    logic          in_y;
    logic          last_x;
    logic          last_y;
    logic          col_last;
    logic          row_last;
    logic          row_end;
    logic          frame_end;
    t_meta         meta_in;

    always_comb begin
        col_end     = KW'(r_col_base) + KW'(bw_eff);
        row_end_pos = KW'(r_row_base) + KW'(bh_eff);
        in_x        = col_end <= w_eff;
        in_y        = row_end_pos <= h_eff;
        last_x      = in_x && ((col_end + KW'(bw_eff)) > w_eff);
        last_y      = in_y && ((row_end_pos + KW'(bh_eff)) > h_eff);
        col_last    = r_col_phase == (bw_eff - 8'd1);
        row_last    = r_row_phase == (bh_eff - 8'd1);
        row_end     = (KW'(r_col_pos) + KW'(1)) >= w_eff;
        frame_end   = row_end && ((KW'(r_row_pos) + KW'(1)) >= h_eff);
        meta_in.in_tile   = in_x && in_y;
        meta_in.first_col = r_col_phase == 8'd0;
        meta_in.first_row = r_row_phase == 8'd0;
        meta_in.last_col  = col_last;
        meta_in.last_row  = row_last;
        meta_in.done      = last_x && last_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_col_pos   <= '0;
            r_col_base  <= '0;
            r_tc        <= '0;
            r_col_phase <= '0;
            r_row_pos   <= '0;
            r_row_base  <= '0;
            r_tr        <= '0;
            r_row_phase <= '0;
        end else if (in_acc) begin
            if (row_end) begin
                r_col_pos   <= '0;
                r_col_base  <= '0;
                r_tc        <= '0;
                r_col_phase <= '0;
                if (frame_end) begin
                    r_row_pos   <= '0;
                    r_row_base  <= '0;
                    r_tr        <= '0;
                    r_row_phase <= '0;
                end else begin
                    r_row_pos <= r_row_pos + RW'(1);
                    if (row_last) begin
                        r_row_phase <= '0;
                        r_tr        <= r_tr + RW'(1);
                        r_row_base  <= RW'(KW'(r_row_base) + KW'(bh_eff));
                    end else begin
                        r_row_phase <= r_row_phase + 8'd1;
                    end
                end
            end else begin
                r_col_pos <= r_col_pos + CW'(1);
                if (col_last) begin
                    r_col_phase <= '0;
                    r_tc        <= r_tc + CW'(1);
                    r_col_base  <= CW'(KW'(r_col_base) + KW'(bw_eff));
                end else begin
                    r_col_phase <= r_col_phase + 8'd1;
                end
            end
        end
    end

    // column extremes ram
    logic             ram_we;
    logic [CW-1:0]    ram_waddr;
    logic [EXT_W-1:0] ram_wdata;
    logic [EXT_W-1:0] ram_rdata;

    mpd_ram #(
        .WIDTH (EXT_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (r_tc),
        .o_rdata (ram_rdata)
    );

    // merge stage
    logic             r_s1_valid;
    t_meta            r_s1_meta;
    logic [PIX_W-1:0] r_s1_pixel;
    logic [CW-1:0]    r_s1_tc;
    logic [RW-1:0]    r_s1_tr;
    logic             r_byp_hit;
    logic [EXT_W-1:0] r_byp_data;
    logic [EXT_W-1:0] r_run;

    logic             s1_emit;
    logic             s1_go;
    logic             s2_go;
    logic             s2_ready;
    logic [EXT_W-1:0] e_src;
    logic [EXT_W-1:0] e_new;

    logic             r_s2_valid;
    logic [EXT_W-1:0] r_s2_e;
    logic [COORD_W-1:0] r_s2_col;
    logic [COORD_W-1:0] r_s2_row;
    logic             r_s2_done;

    logic             r_o_valid;
    logic [PIX_W-1:0] r_o_pixel;
    logic [COORD_W-1:0] r_o_col;
    logic [COORD_W-1:0] r_o_row;
    logic             r_o_done;

    assign s2_go      = r_s2_valid && (!r_o_valid || i_out_ready);
    assign s2_ready   = !r_s2_valid || s2_go;
    assign s1_emit    = r_s1_meta.in_tile && r_s1_meta.last_col && r_s1_meta.last_row;
    assign s1_go      = r_s1_valid && (!s1_emit || s2_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        if (!r_s1_meta.first_col) begin
            e_src = r_run;
        end else if (r_s1_meta.first_row) begin
            e_src = EXT_INIT;
        end else begin
            e_src = r_byp_hit ? r_byp_data : ram_rdata;
        end
        e_new = e_src;
        if (r_fmt) begin
            e_new[15:0]  = merge8(e_src[15:0],  {3'b000, r_s1_pixel[15:11]});
            e_new[31:16] = merge8(e_src[31:16], {2'b00,  r_s1_pixel[10:5]});
            e_new[47:32] = merge8(e_src[47:32], {3'b000, r_s1_pixel[4:0]});
        end else begin
            e_new[15:0]  = merge8(e_src[15:0], r_s1_pixel[7:0]);
        end
    end

    assign ram_we    = s1_go && r_s1_meta.in_tile && r_s1_meta.last_col
                       && !r_s1_meta.last_row;
    assign ram_waddr = r_s1_tc;
    assign ram_wdata = e_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_meta  <= meta_in;
            r_s1_pixel <= i_in_pixel;
            r_s1_tc    <= r_tc;
            r_s1_tr    <= r_tr;
            // write of the leaving item lands in the same edge as this read
            r_byp_hit  <= ram_we && (ram_waddr == r_tc);
            r_byp_data <= ram_wdata;
        end
        if (s1_go && r_s1_meta.in_tile) begin
            r_run <= e_new;
        end
    end

    // blend stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_go && s1_emit) begin
            r_s2_valid <= 1'b1;
        end else if (s2_go) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emit) begin
            r_s2_e    <= e_new;
            r_s2_col  <= COORD_W'(r_s1_tc);
            r_s2_row  <= COORD_W'(r_s1_tr);
            r_s2_done <= r_s1_meta.done;
        end
    end

    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic [PIX_W-1:0] pix_out;

    always_comb begin
        b0 = blend8(r_s2_e[15:0],  wb);
        b1 = blend8(r_s2_e[31:16], wb);
        b2 = blend8(r_s2_e[47:32], wb);
        pix_out = r_fmt ? {b0[4:0], b1[5:0], b2[4:0]} : {8'h00, b0};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s2_go) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_o_pixel <= pix_out;
            r_o_col   <= r_s2_col;
            r_o_row   <= r_s2_row;
            r_o_done  <= r_s2_done;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_pixel  = r_o_pixel;
    assign o_out_col    = r_o_col;
    assign o_out_row    = r_o_row;
    assign o_frame_done = r_o_done;

    `MPD_ASSERT_NXT(a_frame_wrap, in_acc && frame_end && !restart,
        (r_col_pos == '0) && (r_row_pos == '0) && (r_tc == '0) && (r_tr == '0))
    `MPD_ASSERT_IMP(a_col_base, 1'b1,
        (KW'(r_col_pos) == (KW'(r_col_base) + KW'(r_col_phase))))
    `MPD_ASSERT_IMP(a_phase_range, 1'b1, (r_col_phase < bw_eff) && (r_row_phase < bh_eff))

endmodule
`default_nettype wire
